// ===== src/rhbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbm_pkg
// Shared types and constants for the bidirectional window matcher.
// ----------------------------------------------------------------------------
package rhbm_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int MAX_TEXT    = 1024;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 5;
	localparam int PIDX_W      = $clog2(MAX_PATTERN);
	localparam int IDX_W       = 10;
	localparam int POS_MAX     = MAX_TEXT + MAX_PATTERN;
	localparam int POS_W       = $clog2(POS_MAX + 1);
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2
	} rhbm_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              last_byte;
	} rhbm_in_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] start_index;
		logic             reversed_match;
	} rhbm_out_t;

	typedef struct packed {
		logic             norm_hit;
		logic             rev_hit;
		logic [IDX_W-1:0] start;
		logic             last;
	} rhbm_rec_t;

endpackage

// ===== src/rolling_hash_bidirectional_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_hash_bidirectional_matcher_core
// Streaming search for a pattern of up to 16 bytes or its reverse; one
// result per text, given on its final byte.
// ----------------------------------------------------------------------------
//  channel  | signals                        | item
//  in       | in_valid / in_ready / in_data   | one text byte, final-byte flag
//  out      | out_valid / out_ready / out_data| found, start index, direction
//  cfg      | cfg_we / cfg_index / cfg_wdata  | pattern low, high, length
//
//  One byte per cycle while the record queue has room; window compare done in the accept cycle.
//  The final byte's record passes through the record queue, then the result is registered.
//  A four-entry record queue decouples input from a stalled output.
//  Reset clears the window, position, match flags and pattern bytes, and sets the length to 1.
// ----------------------------------------------------------------------------
module rolling_hash_bidirectional_matcher_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rhbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rhbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rhbm_pkg::rhbm_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rhbm_pkg::rhbm_out_t           out_data
);
	import rhbm_pkg::*;

	logic      push;
	logic      push_ready;
	rhbm_rec_t push_data;
	logic      pop;
	logic      pop_valid;
	rhbm_rec_t pop_data;

	rhbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.rec_push  (push),
		.rec_data  (push_data),
		.rec_ready (push_ready)
	);

	rhbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	rhbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (pop_valid),
		.rec_data  (pop_data),
		.rec_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== src/rhbm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbm_front
// Accepts text bytes, shifts the window and classifies each window position
// against the pattern and its reverse.
// ----------------------------------------------------------------------------
module rhbm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rhbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rhbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rhbm_pkg::rhbm_in_t            in_data,
	output logic                          rec_push,
	output rhbm_pkg::rhbm_rec_t           rec_data,
	input  logic                          rec_ready
);
	import rhbm_pkg::*;

	logic [2*CFG_DATA_W-1:0] pat_q;
	logic [LEN_W-1:0]        len_cfg_q;
	logic [BYTE_W-1:0]       win_q [MAX_PATTERN];
	logic [BYTE_W-1:0]       win_next [MAX_PATTERN];
	logic [POS_W-1:0]        pos_q;
	logic [LEN_W-1:0]        len_eff;
	logic [MAX_PATTERN-1:0]  eq_n;
	logic [MAX_PATTERN-1:0]  eq_r;
	logic [MAX_PATTERN-1:0]  mask;
	logic [POS_W:0]          pos1;
	logic [POS_W:0]          start_w;
	logic                    in_window;
	logic                    accept;

	assign in_ready = rec_ready;
	assign accept   = in_valid && in_ready;
	assign rec_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			len_cfg_q <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LOW:  pat_q[CFG_DATA_W-1:0] <= cfg_wdata;
				REG_PAT_HIGH: pat_q[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_wdata;
				REG_PAT_LEN:  len_cfg_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_cfg_q == '0)
			len_eff = LEN_W'(1);
		else if (len_cfg_q > LEN_W'(MAX_PATTERN))
			len_eff = LEN_W'(MAX_PATTERN);
		else
			len_eff = len_cfg_q;
	end

	always_comb begin
		win_next[0] = in_data.text_byte;
		for (int i = 1; i < MAX_PATTERN; i++)
			win_next[i] = win_q[i-1];
	end

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			mask[k] = LEN_W'(k) < len_eff;
			eq_r[k] = win_next[k] == pat_q[k*BYTE_W +: BYTE_W];
			eq_n[k] = win_next[k] ==
				pat_q[PIDX_W'(len_eff - LEN_W'(1) - LEN_W'(k))*BYTE_W +: BYTE_W];
		end
	end

	assign pos1      = {1'b0, pos_q} + (POS_W+1)'(1);
	assign start_w   = pos1 - (POS_W+1)'(len_eff);
	assign in_window = (pos1 >= (POS_W+1)'(len_eff)) && (start_w < (POS_W+1)'(MAX_TEXT));

	always_comb begin
		rec_data.norm_hit = in_window && (&(eq_n | ~mask));
		rec_data.rev_hit  = in_window && (&(eq_r | ~mask));
		rec_data.start    = start_w[IDX_W-1:0];
		rec_data.last     = in_data.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < MAX_PATTERN; i++)
				win_q[i] <= '0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				pos_q <= '0;
				for (int i = 0; i < MAX_PATTERN; i++)
					win_q[i] <= '0;
			end else begin
				if (pos_q < POS_W'(POS_MAX))
					pos_q <= pos_q + POS_W'(1);
				for (int i = 0; i < MAX_PATTERN; i++)
					win_q[i] <= win_next[i];
			end
		end
	end

endmodule

// ===== src/rhbm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbm_queue
// Short record queue between the classifier and the result tracker.
// ----------------------------------------------------------------------------
module rhbm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rhbm_pkg::rhbm_rec_t push_data,
	output logic                push_ready,
	input  logic                pop,
	output logic                pop_valid,
	output rhbm_pkg::rhbm_rec_t pop_data
);
	import rhbm_pkg::*;

	rhbm_rec_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

endmodule

// ===== src/rhbm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhbm_back
// Tracks the first match of each direction and forms the result on the
// final byte of a text.
// ----------------------------------------------------------------------------
module rhbm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	input  rhbm_pkg::rhbm_rec_t rec_data,
	output logic                rec_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output rhbm_pkg::rhbm_out_t out_data
);
	import rhbm_pkg::*;

	logic             norm_seen_q;
	logic [IDX_W-1:0] norm_idx_q;
	logic             rev_seen_q;
	logic [IDX_W-1:0] rev_idx_q;
	logic             out_valid_q;
	rhbm_out_t        out_q;
	logic             norm_any;
	logic             rev_any;
	logic [IDX_W-1:0] norm_idx;
	logic [IDX_W-1:0] rev_idx;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign rec_pop   = rec_valid && (!rec_data.last || !out_valid_q || out_ready);

	assign norm_any = norm_seen_q || rec_data.norm_hit;
	assign rev_any  = rev_seen_q || rec_data.rev_hit;
	assign norm_idx = norm_seen_q ? norm_idx_q : rec_data.start;
	assign rev_idx  = rev_seen_q ? rev_idx_q : rec_data.start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_seen_q <= 1'b0;
			rev_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (rec_pop) begin
				if (rec_data.last) begin
					out_valid_q <= 1'b1;
					norm_seen_q <= 1'b0;
					rev_seen_q  <= 1'b0;
				end else begin
					norm_seen_q <= norm_any;
					rev_seen_q  <= rev_any;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop && !rec_data.last) begin
			norm_idx_q <= norm_idx;
			rev_idx_q  <= rev_idx;
		end
		if (rec_pop && rec_data.last) begin
			if (norm_any) begin
				out_q.found          <= 1'b1;
				out_q.start_index    <= norm_idx;
				out_q.reversed_match <= 1'b0;
			end else if (rev_any) begin
				out_q.found          <= 1'b1;
				out_q.start_index    <= rev_idx;
				out_q.reversed_match <= 1'b1;
			end else begin
				out_q.found          <= 1'b0;
				out_q.start_index    <= '0;
				out_q.reversed_match <= 1'b0;
			end
		end
	end

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.found |-> out_q.start_index == '0 && !out_q.reversed_match)
		else $error("not-found result carries index or direction");

	a_rev_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.reversed_match |-> out_q.found)
		else $error("reversed flag without a match");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rec_pop && rec_data.last))
		else $error("result raised without a final record");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Directed texts from a stimulus table, then random texts that embed the
// pattern, its reverse or near misses. Each result is checked against the
// table's expected value or a local window search. Both channels stall in
// random bursts, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import rhbm_pkg::*;

	localparam int HASH_BASE    = 256;
	localparam int HASH_MOD     = 3355439;
	localparam int DRAIN_CYCLES = 16;
	localparam int RAND_ITEMS   = 300;
	localparam int QUIET_FROM   = 220;
	localparam int SQUEEZE      = 400;
	localparam int ROWS         = 30;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_TEXT,
		ROW_FILL
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		rhbm_reg_t   reg_sel;
		logic [63:0] value;
		logic [127:0] text;
		logic [11:0] nbytes;
		logic        last;
		logic        typed;
		rhbm_out_t   want;
	} plan_row_t;

	localparam rhbm_out_t NONE = '{1'b0, 10'd0, 1'b0};

	localparam plan_row_t PLAN [ROWS] = '{
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h00, 12'd1, 1'b1, 1'b1, '{1'b1, 10'd0, 1'b0}},
		'{ROW_CFG, REG_PAT_LEN, 64'd4, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LOW, 64'h64636261, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_HIGH, 64'h0, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h787861626364, 12'd6, 1'b1, 1'b1,
			'{1'b1, 10'd2, 1'b0}},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h64636261, 12'd4, 1'b1, 1'b1,
			'{1'b1, 10'd0, 1'b1}},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h616263, 12'd3, 1'b1, 1'b1, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h78646362617961626364, 12'd10, 1'b1, 1'b1,
			'{1'b1, 10'd6, 1'b0}},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'hFFFFFFFF, 12'd4, 1'b1, 1'b1, NONE},
		'{ROW_CFG, REG_PAT_LOW, 64'h61626261, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h61626261, 12'd4, 1'b1, 1'b1,
			'{1'b1, 10'd0, 1'b0}},
		'{ROW_CFG, REG_PAT_LEN, 64'd0, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LOW, 64'hFF, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h00FF, 12'd2, 1'b1, 1'b1, '{1'b1, 10'd1, 1'b0}},
		'{ROW_CFG, REG_PAT_LEN, 64'd31, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'hFFFFFFFFFFFFFFFF0000000000000000, 12'd16,
			1'b1, 1'b1, '{1'b1, 10'd0, 1'b0}},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h0000000000000000FFFFFFFFFFFFFFFF, 12'd16,
			1'b1, 1'b1, '{1'b1, 10'd0, 1'b1}},
		'{ROW_CFG, REG_PAT_LEN, 64'd2, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LOW, 64'h0201, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h0301, 12'd2, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LEN, 64'd3, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LOW, 64'h030201, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'h0203, 12'd2, 1'b1, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LOW, 64'hBBAA, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_CFG, REG_PAT_LEN, 64'd2, 128'h0, 12'd0, 1'b0, 1'b0, NONE},
		'{ROW_FILL, REG_PAT_LOW, 64'h11, 128'h0, 12'd1023, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'hBBAA, 12'd2, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, REG_PAT_LOW, 64'h0, 128'hAABB, 12'd2, 1'b1, 1'b1,
			'{1'b1, 10'd1023, 1'b1}},
		'{ROW_CFG, REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0, 12'd0, 1'b0, 1'b0, NONE}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	rhbm_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	rhbm_out_t             out_data;

	logic [63:0]       pat_lo;
	logic [63:0]       pat_hi;
	logic [LEN_W-1:0]  pat_len;
	logic [7:0]        text_win [MAX_PATTERN];
	int                text_pos;
	bit                norm_seen;
	int                norm_at;
	bit                rev_seen;
	int                rev_at;

	rhbm_out_t pending_results [$];
	int        mismatches = 0;
	bit        quiet = 1'b0;
	bit        squeeze_req = 1'b0;
	bit        squeeze_done = 1'b0;

	rolling_hash_bidirectional_matcher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic int effective_length();
		if (pat_len == 0)
			return 1;
		if (pat_len > MAX_PATTERN)
			return MAX_PATTERN;
		return int'(pat_len);
	endfunction

	function automatic logic [7:0] pattern_byte(input int i);
		if (i < 8)
			return pat_lo[8*i +: 8];
		return pat_hi[8*(i-8) +: 8];
	endfunction

	function automatic void clear_search();
		foreach (text_win[i])
			text_win[i] = 8'h00;
		text_pos  = 0;
		norm_seen = 1'b0;
		norm_at   = 0;
		rev_seen  = 1'b0;
		rev_at    = 0;
	endfunction

	function automatic bit advance_search(input logic [7:0] b, input bit last,
		output rhbm_out_t res);
		int     len;
		int     start;
		longint hw;
		longint hp;
		longint hr;
		bit     same;
		for (int i = MAX_PATTERN - 1; i > 0; i--)
			text_win[i] = text_win[i-1];
		text_win[0] = b;
		len = effective_length();
		hw = 0;
		hp = 0;
		hr = 0;
		for (int k = 0; k < len; k++) begin
			hw = (hw * HASH_BASE + text_win[len-1-k]) % HASH_MOD;
			hp = (hp * HASH_BASE + pattern_byte(k)) % HASH_MOD;
			hr = (hr * HASH_BASE + pattern_byte(len-1-k)) % HASH_MOD;
		end
		if (text_pos + 1 >= len) begin
			start = text_pos + 1 - len;
			if (start < MAX_TEXT) begin
				if (!norm_seen && hw == hp) begin
					same = 1'b1;
					for (int k = 0; k < len; k++)
						if (text_win[k] != pattern_byte(len-1-k))
							same = 1'b0;
					if (same) begin
						norm_seen = 1'b1;
						norm_at   = start;
					end
				end
				if (!rev_seen && hw == hr) begin
					same = 1'b1;
					for (int k = 0; k < len; k++)
						if (text_win[k] != pattern_byte(k))
							same = 1'b0;
					if (same) begin
						rev_seen = 1'b1;
						rev_at   = start;
					end
				end
			end
		end
		if (text_pos < POS_MAX)
			text_pos++;
		res = '0;
		if (!last)
			return 1'b0;
		if (norm_seen) begin
			res.found       = 1'b1;
			res.start_index = norm_at[IDX_W-1:0];
		end else if (rev_seen) begin
			res.found          = 1'b1;
			res.start_index    = rev_at[IDX_W-1:0];
			res.reversed_match = 1'b1;
		end
		clear_search();
		return 1'b1;
	endfunction

	task automatic report(input string what, input int want, input int got);
		$display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
		input rhbm_out_t want);
		rhbm_out_t pred;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{text_byte: b, last_byte: last};
		do @(posedge clk); while (!in_ready);
		if (advance_search(b, last, pred))
			pending_results.insert(pending_results.size(), typed ? want : pred);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input rhbm_reg_t sel, input logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_PAT_LOW:  pat_lo = data;
			REG_PAT_HIGH: pat_hi = data;
			REG_PAT_LEN:  pat_len = data[LEN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				out_ready <= 1'b0;
				repeat (SQUEEZE) @(posedge clk);
				squeeze_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		rhbm_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("result with nothing pending", 0, out_data.found);
			end else begin
				want = pending_results.pop_front();
				if (out_data.found !== want.found)
					report("found", want.found, out_data.found);
				if (out_data.start_index !== want.start_index)
					report("start_index", want.start_index, out_data.start_index);
				if (out_data.reversed_match !== want.reversed_match)
					report("reversed_match", want.reversed_match, out_data.reversed_match);
			end
		end
	end

	initial begin
		logic [7:0] text_q [$];
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len_word;
		int  rand_items;
		int  text_no;
		int  eff;
		int  tlen;
		int  mode;
		int  off;
		int  pick;
		bit  small_set;
		rhbm_out_t none;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_PAT_LOW;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		none      = '0;
		pat_lo    = '0;
		pat_hi    = '0;
		pat_len   = 5'd1;
		clear_search();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < ROWS; r++) begin
			case (PLAN[r].kind)
				ROW_CFG: begin
					settle();
					cfg_write(PLAN[r].reg_sel, PLAN[r].value);
				end
				ROW_TEXT: begin
					for (int k = 0; k < PLAN[r].nbytes; k++)
						send_byte(PLAN[r].text[8*(PLAN[r].nbytes-1-k) +: 8],
							PLAN[r].last && k == PLAN[r].nbytes - 1,
							PLAN[r].typed, PLAN[r].want);
				end
				ROW_FILL: begin
					for (int k = 0; k < PLAN[r].nbytes; k++)
						send_byte(PLAN[r].value[7:0], 1'b0, 1'b0, none);
				end
				default: ;
			endcase
		end

		squeeze_req = 1'b1;
		rand_items  = 0;
		text_no     = 0;
		small_set   = 1'b0;
		while (rand_items < RAND_ITEMS) begin
			if (text_no >= 6 && $urandom_range(0, 3) == 0) begin
				settle();
				small_set = $urandom_range(0, 1);
				for (int i = 0; i < 8; i++) begin
					lo[8*i +: 8] = small_set ? 8'h41 + 8'($urandom_range(0, 1))
						: 8'($urandom_range(0, 255));
					hi[8*i +: 8] = small_set ? 8'h41 + 8'($urandom_range(0, 1))
						: 8'($urandom_range(0, 255));
				end
				pick = $urandom_range(0, 9);
				len_word = '0;
				if (pick <= 6) begin
					len_word[LEN_W-1:0] = 5'($urandom_range(1, 6));
				end else if (pick <= 8) begin
					len_word[LEN_W-1:0] = 5'($urandom_range(7, 16));
				end else begin
					len_word = {$urandom, $urandom};
					len_word[LEN_W-1:0] = 5'($urandom_range(0, 31));
				end
				if ($urandom_range(0, 1) == 0) begin
					cfg_write(REG_PAT_LEN, len_word);
					cfg_write(REG_PAT_LOW, lo);
					cfg_write(REG_PAT_HIGH, hi);
				end else begin
					cfg_write(REG_PAT_HIGH, hi);
					cfg_write(REG_PAT_LOW, lo);
					cfg_write(REG_PAT_LEN, len_word);
				end
			end

			eff  = effective_length();
			tlen = $urandom_range(1, 2 * eff + 8);
			text_q.delete();
			for (int k = 0; k < tlen; k++)
				text_q.insert(k, small_set ? 8'h41 + 8'($urandom_range(0, 1))
					: 8'($urandom_range(0, 255)));
			mode = $urandom_range(0, 7);
			if (mode <= 5 && tlen >= eff) begin
				off = $urandom_range(0, tlen - eff);
				for (int k = 0; k < eff; k++)
					text_q[off+k] = (mode >= 3 && mode <= 4) ? pattern_byte(eff-1-k)
						: pattern_byte(k);
				if (mode == 5)
					text_q[off + $urandom_range(0, eff - 1)] ^= 8'(1 << $urandom_range(0, 7));
			end

			for (int k = 0; k < tlen; k++) begin
				send_byte(text_q[k], k == tlen - 1, 1'b0, none);
				rand_items++;
			end
			text_no++;
			if (rand_items >= QUIET_FROM)
				quiet = 1'b1;
		end

		settle();
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
